### src/kpc_pkg.sv
// kpc_pkg: shared types and constants for the key press classifier
// entry layout of the per-key state memory, status codes, register indexes
// no dependencies
package kpc_pkg;

  localparam int NUM_KEYS  = 6;
  localparam int KEY_W     = 3;
  localparam int CNT_W     = 17;
  localparam int CFG_W     = 15;
  localparam int CLICK_W   = 8;
  localparam int STATUS_W  = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic signed [CNT_W-1:0] CNT_MAX   = CNT_W'(32767);
  localparam logic [CLICK_W-1:0]      CLICK_MAX = '1;

  typedef enum logic [STATUS_W-1:0] {
    ST_RELEASED  = 3'd0,
    ST_SHORT     = 3'd1,
    ST_LONG      = 3'd2,
    ST_SHORT_REL = 3'd3,
    ST_LONG_REL  = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRESS_THR = 2'd0,
    CFG_LONG_THR  = 2'd1,
    CFG_IDLE_LIM  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic signed [CNT_W-1:0] cnt;
    logic [STATUS_W-1:0]     status;
    logic [CLICK_W-1:0]      clicks;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [KEY_W-1:0] addr;
    entry_t           data;
  } wr_req_t;

endpackage

### src/kpc_state_ram.sv
// kpc_state_ram: per-key state memory, one write and one registered read port
// entries that were never written since reset read as zero (valid bit per key)
// depends on kpc_pkg
module kpc_state_ram (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic [kpc_pkg::KEY_W-1:0]     rd_addr_i,
  input  kpc_pkg::wr_req_t              wr_i,
  output kpc_pkg::entry_t               rd_data_o
);
  import kpc_pkg::*;

  entry_t               mem [NUM_KEYS];
  logic [NUM_KEYS-1:0]  valid_q;
  entry_t               rd_data_q;
  logic                 rd_hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_hit_q <= 1'b0;
    end else begin
      if (wr_i.we) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_hit_q <= valid_q[rd_addr_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_hit_q ? rd_data_q : '0;

endmodule

### src/kpc_update.sv
// kpc_update: next-state logic for one key tick (counter, status, clicks)
// purely combinational, sits between the memory read and the write-back
// depends on kpc_pkg
module kpc_update (
  input  kpc_pkg::entry_t               cur_i,
  input  logic                          pressed_i,
  input  logic [kpc_pkg::CFG_W-1:0]     press_thr_i,
  input  logic [kpc_pkg::CFG_W-1:0]     long_thr_i,
  input  logic [kpc_pkg::CFG_W-1:0]     idle_lim_i,
  output kpc_pkg::entry_t               nxt_o,
  output logic                          ev_short_o,
  output logic                          ev_long_o
);
  import kpc_pkg::*;

  logic signed [CNT_W-1:0] press_thr_s;
  logic signed [CNT_W-1:0] long_thr_s;
  logic signed [CNT_W-1:0] idle_neg_s;

  assign press_thr_s = $signed({2'b00, press_thr_i});
  assign long_thr_s  = $signed({2'b00, long_thr_i});
  assign idle_neg_s  = -$signed({2'b00, idle_lim_i});

  always_comb begin
    logic signed [CNT_W-1:0] cnt;
    logic [STATUS_W-1:0]     st;
    logic [CLICK_W-1:0]      clk;
    cnt        = cur_i.cnt;
    st         = cur_i.status;
    clk        = cur_i.clicks;
    ev_short_o = 1'b0;
    ev_long_o  = 1'b0;
    if (pressed_i) begin
      if (cnt < 0) begin
        cnt = '0;
      end else if (cnt < CNT_MAX) begin
        cnt = cnt + CNT_W'(1);
      end
      if (cnt > long_thr_s) begin
        st = ST_LONG;
      end else if (cnt > press_thr_s) begin
        st = ST_SHORT;
      end
    end else begin
      if (cnt > 0) begin
        cnt = '0;
      end else if (cnt > idle_neg_s) begin
        cnt = cnt - CNT_W'(1);
      end else begin
        // idle long enough, click run is over
        clk = '0;
      end
      if (st == ST_SHORT) begin
        st         = ST_SHORT_REL;
        ev_short_o = 1'b1;
        if (clk != CLICK_MAX) begin
          clk = clk + CLICK_W'(1);
        end
      end
      if (st == ST_LONG) begin
        st        = ST_LONG_REL;
        ev_long_o = 1'b1;
      end
    end
    nxt_o.cnt    = cnt;
    nxt_o.status = st;
    nxt_o.clicks = clk;
  end

endmodule

### src/key_press_classifier_top.sv
// key_press_classifier_top: top level, pipeline control, config registers
// depends on kpc_pkg, kpc_state_ram, kpc_update
//
// usage:
//   input channel (in_valid_i/in_ready_o) carries one sampled tick of one key:
//   key_index_i and pin_level_i (0 = pressed). a beat with key_index_i of
//   NUM_KEYS or more is accepted and dropped with no result.
//   output channel (out_valid_o/out_ready_i) carries one result beat per
//   in-range tick: key_id_o, key_status_o, clicks_o and the release events.
//   config port: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
//   (0 press threshold, 1 long threshold, 2 idle limit); write only when idle.
// path: an accepted beat is registered in the update stage, then in the output register.
// throughput: one beat per cycle while out_ready_i stays high; the state memory is read
//   in the accept cycle and written back when the beat leaves the update stage,
//   with a forward path when consecutive beats hit the same key.
// reset: all keys released with zero counters and clicks, thresholds 2/150,
//   idle limit 40; no clearing pass, per-key valid bits cover it.
// stall: when out_ready_i is low the output register holds, the update stage
//   holds its beat, and in_ready_o drops once that stage is also occupied.
module key_press_classifier_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [kpc_pkg::KEY_W-1:0]       key_index_i,
  input  logic                            pin_level_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [kpc_pkg::KEY_W-1:0]       key_id_o,
  output logic [kpc_pkg::STATUS_W-1:0]    key_status_o,
  output logic [kpc_pkg::CLICK_W-1:0]     clicks_o,
  output logic                            short_release_event_o,
  output logic                            long_release_event_o,
  input  logic                            cfg_we_i,
  input  logic [kpc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [kpc_pkg::CFG_W-1:0]       cfg_wdata_i
);
  import kpc_pkg::*;

  logic [CFG_W-1:0] press_thr_q, long_thr_q, idle_lim_q;

  logic             s1_valid_q;
  logic [KEY_W-1:0] s1_key_q;
  logic             s1_pressed_q;
  logic             fwd_q;
  entry_t           fwd_data_q;

  logic             out_valid_q;
  logic [KEY_W-1:0] out_key_q;
  entry_t           out_entry_q;
  logic             out_ev_short_q, out_ev_long_q;

  logic             in_accept, in_range, s1_load, s1_adv;
  entry_t           rd_data, cur_entry, nxt_entry;
  logic             ev_short, ev_long;
  wr_req_t          wr_req;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_thr_q <= CFG_W'(2);
      long_thr_q  <= CFG_W'(150);
      idle_lim_q  <= CFG_W'(40);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PRESS_THR: press_thr_q <= cfg_wdata_i;
        CFG_LONG_THR:  long_thr_q  <= cfg_wdata_i;
        CFG_IDLE_LIM:  idle_lim_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_accept  = in_valid_i && in_ready_o;
  assign in_range   = {1'b0, key_index_i} < (KEY_W+1)'(NUM_KEYS);
  assign s1_load    = in_accept && in_range;

  assign wr_req.we   = s1_adv;
  assign wr_req.addr = s1_key_q;
  assign wr_req.data = nxt_entry;

  kpc_state_ram u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (s1_load),
    .rd_addr_i (key_index_i),
    .wr_i      (wr_req),
    .rd_data_o (rd_data)
  );

  // the read missed a write-back of the same key in the accept cycle
  assign cur_entry = fwd_q ? fwd_data_q : rd_data;

  kpc_update u_update (
    .cur_i       (cur_entry),
    .pressed_i   (s1_pressed_q),
    .press_thr_i (press_thr_q),
    .long_thr_i  (long_thr_q),
    .idle_lim_i  (idle_lim_q),
    .nxt_o       (nxt_entry),
    .ev_short_o  (ev_short),
    .ev_long_o   (ev_long)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_q <= 1'b1;
        fwd_q      <= s1_adv && (s1_key_q == key_index_i);
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_key_q     <= key_index_i;
      s1_pressed_q <= !pin_level_i;
      fwd_data_q   <= nxt_entry;
    end
    if (s1_adv) begin
      out_key_q      <= s1_key_q;
      out_entry_q    <= nxt_entry;
      out_ev_short_q <= ev_short;
      out_ev_long_q  <= ev_long;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign key_id_o              = out_key_q;
  assign key_status_o          = out_entry_q.status;
  assign clicks_o              = out_entry_q.clicks;
  assign short_release_event_o = out_ev_short_q;
  assign long_release_event_o  = out_ev_long_q;

endmodule

### src/kpc_checker.sv
// kpc_checker: port-level assertions for key_press_classifier_top
// bound to the top level below; depends on kpc_pkg
module kpc_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            out_valid_o,
  input  logic                            out_ready_i,
  input  logic [kpc_pkg::KEY_W-1:0]       key_id_o,
  input  logic [kpc_pkg::STATUS_W-1:0]    key_status_o,
  input  logic [kpc_pkg::CLICK_W-1:0]     clicks_o,
  input  logic                            short_release_event_o,
  input  logic                            long_release_event_o
);
  import kpc_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(key_id_o) &&
      $stable(key_status_o) && $stable(clicks_o))
    else $error("result beat changed while stalled");

  a_short_ev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && short_release_event_o |->
      key_status_o == ST_SHORT_REL && clicks_o != '0)
    else $error("short release event without short release status");

  a_long_ev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && long_release_event_o |->
      key_status_o == ST_LONG_REL && !short_release_event_o)
    else $error("long release event inconsistent");

  a_key_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> {1'b0, key_id_o} < (KEY_W+1)'(NUM_KEYS))
    else $error("result for a key out of range");

endmodule

bind key_press_classifier_top kpc_checker u_kpc_checker (
  .clk_i                 (clk_i),
  .rst_ni                (rst_ni),
  .out_valid_o           (out_valid_o),
  .out_ready_i           (out_ready_i),
  .key_id_o              (key_id_o),
  .key_status_o          (key_status_o),
  .clicks_o              (clicks_o),
  .short_release_event_o (short_release_event_o),
  .long_release_event_o  (long_release_event_o)
);
